/* sv/tlge_pkg.sv */
// tlge_pkg: shared types and constants for the toroidal life grid engine
// depends on nothing; used by the controller, datapath and top level

package tlge_pkg;

   // width of the row index field on the result channel
   localparam int unsigned ROW_INDEX_W = 4;
   // width of the row bit fields on the result channel
   localparam int unsigned ROW_BITS_W  = 16;

   // b3/s23 rule counts
   localparam int unsigned BIRTH_COUNT   = 3;
   localparam int unsigned SURVIVE_LOW   = 2;
   localparam int unsigned SURVIVE_HIGH  = 3;
   // neighbor count fits 0 to 8
   localparam int unsigned NEIGHBOR_MAX  = 8;
   localparam int unsigned NEIGHBOR_W    = $clog2(NEIGHBOR_MAX + 1);

   // action codes of the request word
   typedef enum logic {
      ACT_PRESS = 1'b0,
      ACT_TICK  = 1'b1
   } action_type;

   // controller to datapath commands
   typedef struct packed {
      logic                   press;   // mark the pressed cell
      logic                   step;    // process the head row of the ring
      logic                   first;   // step is for row 0
      logic                   last;    // step is for the final row
      logic [ROW_INDEX_W-1:0] row;     // row index shown on the result
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;                  // result register can take a word
   } status_type;

endpackage

/* sv/toroidal_life_grid_engine.sv */
// toroidal_life_grid_engine: b3/s23 life on a wrap-around grid
// depends on tlge_pkg, tlge_ctrl and tlge_datapath
//
// Usage:
//   Request words (req_*) carry an action: a press marks one cell to flip,
//   a tick flips all marked cells, clears the marks and computes the marks
//   for the next tick by the b3/s23 rule over the eight toroidal neighbors.
//   A press outside the grid is dropped. A press gives no response words.
//   A tick gives GRID_ROWS response words (rsp_*), rows 0 upward, each with
//   the new live bits, the bits that flipped, and last set on the final row.
//   A tick streams one row per cycle out of a rotating row ring, as long as
//   the response register is not held by a stalled word. On acceptance the
//   controller enters its run state; each row then goes through the rule
//   unit and is registered into the response register as the ring rotates.
//   req_stall is high while a tick is running; a new word is taken as soon
//   as the last row sits in the response register, even if not yet taken.
//   When a valid word is stalled by rsp_stall, the response register holds and the ring waits.
//   Reset clears both grids: all cells dead, no flips pending.

module toroidal_life_grid_engine #(
   parameter int unsigned GRID_COLS = 16,
   parameter int unsigned GRID_ROWS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [3:0]  req_press_col,
   input  logic [3:0]  req_press_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_row_index,
   output logic [15:0] rsp_row_alive,
   output logic [15:0] rsp_row_changed,
   output logic        rsp_last
);

   tlge_pkg::cmd_type    cmd;
   tlge_pkg::status_type status;

   // controller
   tlge_ctrl #(
      .GRID_ROWS (GRID_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   tlge_datapath #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_press_col   (req_press_col),
      .req_press_row   (req_press_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_index   (rsp_row_index),
      .rsp_row_alive   (rsp_row_alive),
      .rsp_row_changed (rsp_row_changed),
      .rsp_last        (rsp_last)
   );

endmodule

/* sv/tlge_ctrl.sv */
// tlge_ctrl: controller state machine, request handshake and row counter
// depends on tlge_pkg

module tlge_ctrl #(
   parameter int unsigned GRID_ROWS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_stall,
   input  tlge_pkg::status_type status,
   output tlge_pkg::cmd_type    cmd
);

   localparam int unsigned CNT_W = $clog2(GRID_ROWS);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             is_last;
   logic [CNT_W+tlge_pkg::ROW_INDEX_W-1:0] row_wide;

   // request side is open only between runs
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign is_last   = (cnt_ff == CNT_W'(GRID_ROWS - 1));
   assign row_wide  = {{tlge_pkg::ROW_INDEX_W{1'b0}}, cnt_ff};

   // command decode
   always_comb begin
      cmd       = '0;
      cmd.press = accept & (req_action == tlge_pkg::ACT_PRESS);
      cmd.step  = (state_ff == ST_RUN) & status.out_free;
      cmd.first = (cnt_ff == '0);
      cmd.last  = is_last;
      cmd.row   = row_wide[tlge_pkg::ROW_INDEX_W-1:0];
   end

   // next state and row counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_action == tlge_pkg::ACT_TICK) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (cmd.step) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* sv/tlge_datapath.sv */
// tlge_datapath: live and flip row rings, neighbor rule and result register
// depends on tlge_pkg

module tlge_datapath #(
   parameter int unsigned GRID_COLS = 16,
   parameter int unsigned GRID_ROWS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlge_pkg::cmd_type      cmd,
   output tlge_pkg::status_type   status,
   input  logic [3:0]             req_press_col,
   input  logic [3:0]             req_press_row,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [tlge_pkg::ROW_INDEX_W-1:0] rsp_row_index,
   output logic [tlge_pkg::ROW_BITS_W-1:0]  rsp_row_alive,
   output logic [tlge_pkg::ROW_BITS_W-1:0]  rsp_row_changed,
   output logic                   rsp_last
);

   localparam int unsigned ROW_W = $clog2(GRID_ROWS);
   localparam int unsigned COL_W = $clog2(GRID_COLS);

   logic [GRID_COLS-1:0] live_ff [GRID_ROWS];
   logic [GRID_COLS-1:0] live_in [GRID_ROWS];
   logic [GRID_COLS-1:0] flip_ff [GRID_ROWS];
   logic [GRID_COLS-1:0] flip_in [GRID_ROWS];

   logic [GRID_COLS-1:0] above, head, below, marks;

   logic                 press_ok;
   logic [ROW_W+3:0]     prow_wide;
   logic [COL_W+3:0]     pcol_wide;
   logic [ROW_W-1:0]     prow_idx;
   logic [COL_W-1:0]     pcol_idx;
   logic [GRID_COLS-1:0] press_bit;

   logic [tlge_pkg::ROW_BITS_W+GRID_COLS-1:0] alive_wide, changed_wide;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [tlge_pkg::ROW_INDEX_W-1:0] row_index_ff;
   logic [tlge_pkg::ROW_BITS_W-1:0]  row_alive_ff, row_changed_ff;
   logic                 last_ff;

   // three-row window at fixed ring places; flips applied where not yet done
   assign head  = live_ff[0] ^ flip_ff[0];
   assign above = cmd.first ? (live_ff[GRID_ROWS-1] ^ flip_ff[GRID_ROWS-1])
                            : live_ff[GRID_ROWS-1];
   assign below = cmd.last  ? live_ff[1] : (live_ff[1] ^ flip_ff[1]);

   // per-column b3/s23 rule on the head row
   for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
      localparam int unsigned CL = (c + GRID_COLS - 1) % GRID_COLS;
      localparam int unsigned CR = (c + 1) % GRID_COLS;
      logic [tlge_pkg::NEIGHBOR_W-1:0] n;
      assign n = tlge_pkg::NEIGHBOR_W'(above[CL]) + tlge_pkg::NEIGHBOR_W'(above[c])
               + tlge_pkg::NEIGHBOR_W'(above[CR]) + tlge_pkg::NEIGHBOR_W'(head[CL])
               + tlge_pkg::NEIGHBOR_W'(head[CR])  + tlge_pkg::NEIGHBOR_W'(below[CL])
               + tlge_pkg::NEIGHBOR_W'(below[c])  + tlge_pkg::NEIGHBOR_W'(below[CR]);
      assign marks[c] = head[c]
         ? (n != tlge_pkg::NEIGHBOR_W'(tlge_pkg::SURVIVE_LOW) &&
            n != tlge_pkg::NEIGHBOR_W'(tlge_pkg::SURVIVE_HIGH))
         : (n == tlge_pkg::NEIGHBOR_W'(tlge_pkg::BIRTH_COUNT));
   end

   // press decode, out-of-grid presses are dropped
   assign press_ok  = (32'(req_press_col) < GRID_COLS) && (32'(req_press_row) < GRID_ROWS);
   assign prow_wide = {{ROW_W{1'b0}}, req_press_row};
   assign pcol_wide = {{COL_W{1'b0}}, req_press_col};
   assign prow_idx  = prow_wide[ROW_W-1:0];
   assign pcol_idx  = pcol_wide[COL_W-1:0];
   assign press_bit = GRID_COLS'(1) << pcol_idx;

   // ring update: rotate on a step, or set one flip mark on a press
   always_comb begin
      for (int i = 0; i < GRID_ROWS; i++) begin
         live_in[i] = live_ff[i];
         flip_in[i] = flip_ff[i];
      end
      if (cmd.step) begin
         for (int i = 0; i < GRID_ROWS - 1; i++) begin
            live_in[i] = live_ff[i+1];
            flip_in[i] = flip_ff[i+1];
         end
         live_in[GRID_ROWS-1] = head;
         flip_in[GRID_ROWS-1] = marks;
      end else if (cmd.press && press_ok) begin
         flip_in[prow_idx] = flip_ff[prow_idx] | press_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRID_ROWS; i++) begin
            live_ff[i] <= '0;
            flip_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < GRID_ROWS; i++) begin
            live_ff[i] <= live_in[i];
            flip_ff[i] <= flip_in[i];
         end
      end
   end

   // result register
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in    = cmd.step | (rsp_valid_ff & rsp_stall);
   assign alive_wide      = {{tlge_pkg::ROW_BITS_W{1'b0}}, head};
   assign changed_wide    = {{tlge_pkg::ROW_BITS_W{1'b0}}, flip_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         row_index_ff   <= cmd.row;
         row_alive_ff   <= alive_wide[tlge_pkg::ROW_BITS_W-1:0];
         row_changed_ff <= changed_wide[tlge_pkg::ROW_BITS_W-1:0];
         last_ff        <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_index   = row_index_ff;
   assign rsp_row_alive   = row_alive_ff;
   assign rsp_row_changed = row_changed_ff;
   assign rsp_last        = last_ff;

endmodule

/* sv/tlge_checker.sv */
// tlge_checker: port-level checks for the life grid engine, bound to the top
// depends on toroidal_life_grid_engine ports only

module tlge_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_action,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_row_index,
   input logic        rsp_last
);

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_index) && $stable(rsp_last))
      else $error("stalled response word changed");

   // an accepted tick closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action |=> req_stall)
      else $error("request taken during a tick run");

   // rows of one run follow back to back in order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last
      |=> rsp_valid && rsp_row_index == $past(rsp_row_index) + 4'd1)
      else $error("tick run row sequence broken");

   // an accepted press leaves the request side open
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_action |=> !req_stall)
      else $error("request side closed after a press");

endmodule

bind toroidal_life_grid_engine tlge_checker u_tlge_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_row_index (rsp_row_index),
   .rsp_last      (rsp_last)
);
